// ===== rtl/lrda_pkg.sv =====
package lrda_pkg;

  // Adler-32 arithmetic
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam int          SUM_SHIFT = 16;

  // Record framing
  localparam logic [7:0] END_MARK     = 8'h42;
  localparam int         DEPS_DEFAULT = 5;
  localparam int         DEP_CNT_W    = 8;

  typedef enum logic [3:0] {
    PH_LEN      = 4'd0,
    PH_BALLOT   = 4'd1,
    PH_STATUS   = 4'd2,
    PH_SEQ      = 4'd3,
    PH_DEP      = 4'd4,
    PH_CMDCOUNT = 4'd5,
    PH_OP       = 4'd6,
    PH_KEYLEN   = 4'd7,
    PH_KEYBYTE  = 4'd8,
    PH_VALLEN   = 4'd9,
    PH_VALBYTE  = 4'd10,
    PH_CHECK    = 4'd11,
    PH_END      = 4'd12
  } phase_t;

  // Result kinds
  localparam logic [3:0] KIND_LENGTH   = 4'd0;
  localparam logic [3:0] KIND_BALLOT   = 4'd1;
  localparam logic [3:0] KIND_STATUS   = 4'd2;
  localparam logic [3:0] KIND_SEQ      = 4'd3;
  localparam logic [3:0] KIND_DEP      = 4'd4;
  localparam logic [3:0] KIND_CMDCOUNT = 4'd5;
  localparam logic [3:0] KIND_OP       = 4'd6;
  localparam logic [3:0] KIND_KEYLEN   = 4'd7;
  localparam logic [3:0] KIND_KEYBYTE  = 4'd8;
  localparam logic [3:0] KIND_VALLEN   = 4'd9;
  localparam logic [3:0] KIND_VALBYTE  = 4'd10;
  localparam logic [3:0] KIND_OK       = 4'd11;
  localparam logic [3:0] KIND_ERROR    = 4'd12;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHECKSUM = 2'd1;
  localparam logic [1:0] ERR_END_MARK = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] index;
    logic [31:0] value;
    logic [1:0]  err;
    logic        last;
  } result_t;

  // One Adler-32 byte step: returns {sum_high, sum_low}
  function automatic logic [31:0] adler_step(input logic [15:0] lo,
                                             input logic [15:0] hi,
                                             input logic [7:0]  b);
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    lo_sum = {1'b0, lo} + {9'd0, b};
    if (lo_sum >= ADLER_MOD) lo_sum = lo_sum - ADLER_MOD;
    hi_sum = {1'b0, hi} + lo_sum;
    if (hi_sum >= ADLER_MOD) hi_sum = hi_sum - ADLER_MOD;
    return {hi_sum[15:0], lo_sum[15:0]};
  endfunction

  // Count word with the top bit set counts as zero
  function automatic logic [31:0] count_of(input logic [31:0] w);
    return w[31] ? 32'd0 : w;
  endfunction

endpackage

// ===== rtl/log_record_deframer_adler32.sv =====
// Log record deframer with Adler-32 check. Takes one byte of a stored log
// stream per transaction on the input channel (data_byte) and parses records
// of little-endian 32-bit words: length, ballot, status, seq, DEPS dependency
// words, command count, then per command an opcode, a key length with its key
// bytes and a value length with its value bytes, followed by the stored
// Adler-32 and an end byte 0x42. Each completed word and each payload byte
// gives one result transaction (field_kind, field_index, field_value); the
// first three bytes of a word and a matching checksum word give none. A good
// end byte gives an ok result with record_last set and parsing starts over on
// the next record. A checksum mismatch or a bad end byte gives an error
// result (field_value carries the computed checksum) and the block then
// swallows every byte without a result until rst. Rate: one byte per clock
// cycle while in_stall is low; all parsing and both Adler sums for a byte
// are combinational from the parser state registers into the result
// register (or the skid register while the output is held). A one-deep
// skid register behind the result register absorbs a stalled output; in_stall
// rises only while that skid register is occupied.
module log_record_deframer_adler32 #(
  parameter int DEPS = lrda_pkg::DEPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  field_kind,
  output logic [31:0] field_index,
  output logic [31:0] field_value,
  output logic [1:0]  error_kind,
  output logic        record_last
);

  // Parser state
  lrda_pkg::phase_t                 phase, phase_next;
  logic [1:0]                       byte_in_word, byte_in_word_next;
  logic [31:0]                      word_assembly, word_assembly_next;
  logic [31:0]                      record_offset, record_offset_next;
  logic [31:0]                      record_length, record_length_next;
  logic [15:0]                      sum_low, sum_low_next;
  logic [15:0]                      sum_high, sum_high_next;
  logic [lrda_pkg::DEP_CNT_W-1:0]   dep_counter, dep_counter_next;
  logic [31:0]                      commands_total, commands_total_next;
  logic [31:0]                      command_counter, command_counter_next;
  logic [31:0]                      payload_left, payload_left_next;
  logic                             halted, halted_next;

  // Result register and skid
  lrda_pkg::result_t out_data, skid_data, res;
  logic              skid_valid;
  logic              res_valid;

  logic        accept;
  logic        active;
  logic [31:0] word_merged;
  logic [31:0] word_full;
  logic        word_done;
  logic        add_en;
  logic [31:0] adler_next;
  logic [31:0] computed_sum;
  logic [31:0] payload_dec;
  logic [31:0] cmd_inc;
  logic        cmd_last;
  logic [lrda_pkg::DEP_CNT_W-1:0] dep_inc;
  logic [31:0] cnt_w;
  logic        restart;

  // Length word folding: sums always start at 1/0 here, so no wrap occurs
  logic [10:0] fold_l1, fold_l2, fold_l3, fold_l4;
  logic [12:0] fold_h;
  logic [10:0] fold_l;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign active   = accept && !halted;

  // Assemble the current byte into the word being collected
  assign word_merged = word_assembly | ({24'd0, data_byte} << {byte_in_word, 3'b000});
  assign word_full   = {data_byte, word_assembly[23:0]};
  assign word_done   = (byte_in_word == 2'd3);

  assign add_en = (phase != lrda_pkg::PH_LEN) && (phase < lrda_pkg::PH_CHECK) &&
                  (record_offset >= 32'd4) && (record_offset < record_length);
  assign adler_next   = lrda_pkg::adler_step(sum_low, sum_high, data_byte);
  assign computed_sum = {sum_high, sum_low};

  assign payload_dec = payload_left - 32'd1;
  assign cmd_inc     = command_counter + 32'd1;
  assign cmd_last    = (cmd_inc == commands_total);
  assign dep_inc     = dep_counter + 1'b1;
  assign cnt_w       = lrda_pkg::count_of(word_full);

  assign fold_l1 = 11'd1 + {3'd0, word_full[7:0]};
  assign fold_l2 = fold_l1 + {3'd0, word_full[15:8]};
  assign fold_l3 = fold_l2 + {3'd0, word_full[23:16]};
  assign fold_l4 = fold_l3 + {3'd0, word_full[31:24]};

  always_comb begin
    if (word_full > 32'd3) begin
      fold_l = fold_l4;
      fold_h = {2'd0, fold_l1} + {2'd0, fold_l2} + {2'd0, fold_l3} + {2'd0, fold_l4};
    end else begin
      case (word_full[1:0])
        2'd1: begin
          fold_l = fold_l1;
          fold_h = {2'd0, fold_l1};
        end
        2'd2: begin
          fold_l = fold_l2;
          fold_h = {2'd0, fold_l1} + {2'd0, fold_l2};
        end
        2'd3: begin
          fold_l = fold_l3;
          fold_h = {2'd0, fold_l1} + {2'd0, fold_l2} + {2'd0, fold_l3};
        end
        default: begin
          fold_l = 11'd1;
          fold_h = 13'd0;
        end
      endcase
    end
  end

  // Next-state logic
  always_comb begin
    phase_next           = phase;
    byte_in_word_next    = byte_in_word;
    word_assembly_next   = word_assembly;
    record_offset_next   = record_offset;
    record_length_next   = record_length;
    sum_low_next         = sum_low;
    sum_high_next        = sum_high;
    dep_counter_next     = dep_counter;
    commands_total_next  = commands_total;
    command_counter_next = command_counter;
    payload_left_next    = payload_left;
    halted_next          = halted;
    restart              = 1'b0;

    if (active) begin
      record_offset_next = record_offset + 32'd1;
      if (add_en) begin
        sum_low_next  = adler_next[15:0];
        sum_high_next = adler_next[31:16];
      end

      case (phase)
        lrda_pkg::PH_KEYBYTE: begin
          payload_left_next = payload_dec;
          if (payload_dec == 32'd0) phase_next = lrda_pkg::PH_VALLEN;
        end
        lrda_pkg::PH_VALBYTE: begin
          payload_left_next = payload_dec;
          if (payload_dec == 32'd0) begin
            command_counter_next = cmd_inc;
            phase_next = cmd_last ? lrda_pkg::PH_CHECK : lrda_pkg::PH_OP;
          end
        end
        lrda_pkg::PH_END: begin
          if (data_byte == lrda_pkg::END_MARK) restart = 1'b1;
          else halted_next = 1'b1;
        end
        lrda_pkg::PH_LEN, lrda_pkg::PH_BALLOT, lrda_pkg::PH_STATUS,
        lrda_pkg::PH_SEQ, lrda_pkg::PH_DEP, lrda_pkg::PH_CMDCOUNT,
        lrda_pkg::PH_OP, lrda_pkg::PH_KEYLEN, lrda_pkg::PH_VALLEN,
        lrda_pkg::PH_CHECK: begin
          if (!word_done) begin
            word_assembly_next = word_merged;
            byte_in_word_next  = byte_in_word + 2'd1;
          end else begin
            word_assembly_next = 32'd0;
            byte_in_word_next  = 2'd0;
            case (phase)
              lrda_pkg::PH_LEN: begin
                record_length_next = word_full;
                sum_low_next       = {5'd0, fold_l};
                sum_high_next      = {3'd0, fold_h};
                phase_next         = lrda_pkg::PH_BALLOT;
              end
              lrda_pkg::PH_BALLOT: phase_next = lrda_pkg::PH_STATUS;
              lrda_pkg::PH_STATUS: phase_next = lrda_pkg::PH_SEQ;
              lrda_pkg::PH_SEQ: begin
                dep_counter_next = '0;
                phase_next       = lrda_pkg::PH_DEP;
              end
              lrda_pkg::PH_DEP: begin
                dep_counter_next = dep_inc;
                if (dep_inc >= lrda_pkg::DEP_CNT_W'(DEPS)) phase_next = lrda_pkg::PH_CMDCOUNT;
              end
              lrda_pkg::PH_CMDCOUNT: begin
                commands_total_next  = cnt_w;
                command_counter_next = 32'd0;
                phase_next = (cnt_w == 32'd0) ? lrda_pkg::PH_CHECK : lrda_pkg::PH_OP;
              end
              lrda_pkg::PH_OP: phase_next = lrda_pkg::PH_KEYLEN;
              lrda_pkg::PH_KEYLEN: begin
                payload_left_next = cnt_w;
                phase_next = (cnt_w == 32'd0) ? lrda_pkg::PH_VALLEN : lrda_pkg::PH_KEYBYTE;
              end
              lrda_pkg::PH_VALLEN: begin
                payload_left_next = cnt_w;
                if (cnt_w == 32'd0) begin
                  command_counter_next = cmd_inc;
                  phase_next = cmd_last ? lrda_pkg::PH_CHECK : lrda_pkg::PH_OP;
                end else begin
                  phase_next = lrda_pkg::PH_VALBYTE;
                end
              end
              lrda_pkg::PH_CHECK: begin
                if (word_full != computed_sum) halted_next = 1'b1;
                else phase_next = lrda_pkg::PH_END;
              end
              default: restart = 1'b1;
            endcase
          end
        end
        default: restart = 1'b1;
      endcase

      // Start a fresh record: everything but the halt flag goes back to reset
      if (restart) begin
        phase_next           = lrda_pkg::PH_LEN;
        byte_in_word_next    = 2'd0;
        word_assembly_next   = 32'd0;
        record_offset_next   = 32'd0;
        record_length_next   = 32'd0;
        sum_low_next         = 16'd1;
        sum_high_next        = 16'd0;
        dep_counter_next     = '0;
        commands_total_next  = 32'd0;
        command_counter_next = 32'd0;
        payload_left_next    = 32'd0;
      end
    end
  end

  // Result decode
  always_comb begin
    res_valid = 1'b0;
    res.kind  = lrda_pkg::KIND_LENGTH;
    res.index = 32'd0;
    res.value = word_full;
    res.err   = lrda_pkg::ERR_NONE;
    res.last  = 1'b0;

    if (active) begin
      case (phase)
        lrda_pkg::PH_KEYBYTE, lrda_pkg::PH_VALBYTE: begin
          res_valid = 1'b1;
          res.kind  = (phase == lrda_pkg::PH_KEYBYTE) ? lrda_pkg::KIND_KEYBYTE
                                                      : lrda_pkg::KIND_VALBYTE;
          res.index = command_counter;
          res.value = {24'd0, data_byte};
        end
        lrda_pkg::PH_END: begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (data_byte == lrda_pkg::END_MARK) begin
            res.kind  = lrda_pkg::KIND_OK;
            res.value = {24'd0, data_byte};
          end else begin
            res.kind  = lrda_pkg::KIND_ERROR;
            res.value = computed_sum;
            res.err   = lrda_pkg::ERR_END_MARK;
          end
        end
        lrda_pkg::PH_LEN: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_LENGTH;
        end
        lrda_pkg::PH_BALLOT: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_BALLOT;
        end
        lrda_pkg::PH_STATUS: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_STATUS;
        end
        lrda_pkg::PH_SEQ: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_SEQ;
        end
        lrda_pkg::PH_DEP: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_DEP;
          res.index = {{(32 - lrda_pkg::DEP_CNT_W){1'b0}}, dep_counter};
        end
        lrda_pkg::PH_CMDCOUNT: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_CMDCOUNT;
        end
        lrda_pkg::PH_OP: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_OP;
          res.index = command_counter;
        end
        lrda_pkg::PH_KEYLEN: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_KEYLEN;
          res.index = command_counter;
        end
        lrda_pkg::PH_VALLEN: begin
          res_valid = word_done;
          res.kind  = lrda_pkg::KIND_VALLEN;
          res.index = command_counter;
        end
        lrda_pkg::PH_CHECK: begin
          // matching checksum advances silently
          res_valid = word_done && (word_full != computed_sum);
          res.kind  = lrda_pkg::KIND_ERROR;
          res.value = computed_sum;
          res.err   = lrda_pkg::ERR_CHECKSUM;
          res.last  = 1'b1;
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lrda_pkg::PH_LEN;
      byte_in_word    <= 2'd0;
      word_assembly   <= 32'd0;
      record_offset   <= 32'd0;
      record_length   <= 32'd0;
      sum_low         <= 16'd1;
      sum_high        <= 16'd0;
      dep_counter     <= '0;
      commands_total  <= 32'd0;
      command_counter <= 32'd0;
      payload_left    <= 32'd0;
      halted          <= 1'b0;
    end else begin
      phase           <= phase_next;
      byte_in_word    <= byte_in_word_next;
      word_assembly   <= word_assembly_next;
      record_offset   <= record_offset_next;
      record_length   <= record_length_next;
      sum_low         <= sum_low_next;
      sum_high        <= sum_high_next;
      dep_counter     <= dep_counter_next;
      commands_total  <= commands_total_next;
      command_counter <= command_counter_next;
      payload_left    <= payload_left_next;
      halted          <= halted_next;
    end
  end

  // Result register with skid: a new result lands in the skid register only
  // while the output is held; the skid drains into the output first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (res_valid) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (res_valid) skid_data <= res;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (res_valid) begin
      out_data <= res;
    end
  end

  assign field_kind  = out_data.kind;
  assign field_index = out_data.index;
  assign field_value = out_data.value;
  assign error_kind  = out_data.err;
  assign record_last = out_data.last;

  // The length phase always sees freshly initialized sums (fold relies on it)
  assert property (@(posedge clk) disable iff (rst)
    (phase == lrda_pkg::PH_LEN) |-> (sum_low == 16'd1 && sum_high == 16'd0))
    else $error("sums not at initial value in length phase");

  // Halt holds until reset
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt released without reset");

  // Skid register only fills behind an occupied output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid occupied with empty output register");

  // Error results always close a record with a nonzero error code
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_kind == lrda_pkg::KIND_ERROR) |->
      (record_last && error_kind != lrda_pkg::ERR_NONE))
    else $error("error result without record_last or error code");

endmodule
